FILE: design/pic_pkg.sv
// Shared types, register map and reset values for the clamped PI controller.
package pic_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned ERR_W   = DATA_W + 1;      // target - sensed, exact
    localparam int unsigned ESUM_W  = ERR_W + 1;       // err + last err
    localparam int unsigned PROP_W  = DATA_W + ERR_W;  // Q17.16 proportional term
    localparam int unsigned GS_W    = 2 * DATA_W + 1;  // integ_gain * step_time
    localparam int unsigned INC_W   = GS_W + ESUM_W;   // Q.32 increment
    localparam int unsigned INTEG_W = 32;              // Q8.24 integrator
    localparam int unsigned ACC_W   = INC_W - 9 + 1;   // integrator plus rounded increment
    localparam int unsigned SUM_W   = PROP_W + 8 + 1;  // Q.24 output sum
    localparam int unsigned IDX_W   = 3;

    typedef logic [IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_PROP_GAIN   = 3'd0;
    localparam reg_idx_t REG_INTEG_GAIN  = 3'd1;
    localparam reg_idx_t REG_STEP_TIME   = 3'd2;
    localparam reg_idx_t REG_INTEG_UPPER = 3'd3;
    localparam reg_idx_t REG_INTEG_LOWER = 3'd4;
    localparam reg_idx_t REG_DRIVE_UPPER = 3'd5;
    localparam reg_idx_t REG_DRIVE_LOWER = 3'd6;

    localparam logic [DATA_W-1:0] BOUND_MAX = 16'h7fff;
    localparam logic [DATA_W-1:0] BOUND_MIN = 16'h8000;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic load;    // capture the input item, form the error
        logic mul;     // proportional product, gain*step product, error sum
        logic prod;    // integrator increment product
        logic accum;   // add increment, clamp, update state
        logic drive;   // form output, clamp, load result register
    } pic_cmd_t;

    typedef struct packed {
        logic out_free; // result register empty or being taken this cycle
    } pic_stat_t;

endpackage

FILE: design/pic_ctrl.sv
// Sequencer for the clamped PI controller: steps each item through the datapath.
module pic_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pic_pkg::pic_stat_t stat,
    output pic_pkg::pic_cmd_t  cmd
);
    import pic_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_PROD  = 5'b00100,
        ST_ACCUM = 5'b01000,
        ST_DRIVE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // the next item may enter in the cycle its predecessor's result is loaded
    assign s_ready = (state_reg == ST_IDLE) ||
                     ((state_reg == ST_DRIVE) && stat.out_free);

    always_comb begin
        cmd        = '0;
        cmd.load   = s_valid && s_ready;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = ST_DRIVE;
            end
            ST_DRIVE: begin
                cmd.drive = stat.out_free;
                if (stat.out_free) begin
                    state_next = s_valid ? ST_MUL : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/pic_dpath.sv
// Datapath of the clamped PI controller: config registers, multipliers, integrator, clamps.
module pic_dpath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  pic_pkg::reg_idx_t                cfg_index,
    input  logic        [pic_pkg::DATA_W-1:0] cfg_data,
    input  logic signed [pic_pkg::DATA_W-1:0] s_target_value,
    input  logic signed [pic_pkg::DATA_W-1:0] s_sensed_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [pic_pkg::DATA_W-1:0] m_drive_value,
    output logic                             m_drive_clamped,
    input  pic_pkg::pic_cmd_t                cmd,
    output pic_pkg::pic_stat_t               stat
);
    import pic_pkg::*;

    logic signed [DATA_W-1:0]  prop_gain_reg, integ_gain_reg;
    logic        [DATA_W-1:0]  step_time_reg;
    logic signed [DATA_W-1:0]  integ_upper_reg, integ_lower_reg;
    logic signed [DATA_W-1:0]  drive_upper_reg, drive_lower_reg;

    logic signed [ERR_W-1:0]   err_reg, last_err_reg;
    logic signed [ESUM_W-1:0]  esum_reg;
    logic signed [PROP_W-1:0]  prop_reg;
    logic signed [GS_W-1:0]    gs_reg;
    logic signed [INC_W-1:0]   inc_reg;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;

    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  drive_reg, drive_next;
    logic                      clamped_reg, clamped_next;

    logic signed [INC_W-1:0]   inc_rnd;
    logic signed [ACC_W-1:0]   acc_raw, iu_ext, il_ext;
    logic signed [SUM_W-1:0]   sum, du_ext, dl_ext, sum_rnd;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            step_time_reg   <= '0;
            integ_upper_reg <= BOUND_MAX;
            integ_lower_reg <= BOUND_MIN;
            drive_upper_reg <= BOUND_MAX;
            drive_lower_reg <= BOUND_MIN;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_data;
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data;
                REG_STEP_TIME:   step_time_reg   <= cfg_data;
                REG_INTEG_UPPER: integ_upper_reg <= cfg_data;
                REG_INTEG_LOWER: integ_lower_reg <= cfg_data;
                REG_DRIVE_UPPER: drive_upper_reg <= cfg_data;
                REG_DRIVE_LOWER: drive_lower_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // integrator step: round half up from Q.32 halved to Q8.24, then clamp upper first
    always_comb begin
        inc_rnd = (inc_reg + INC_W'(256)) >>> 9;
        acc_raw = ACC_W'(integ_reg) + ACC_W'(inc_rnd);
        iu_ext  = ACC_W'($signed({integ_upper_reg, 16'h0000}));
        il_ext  = ACC_W'($signed({integ_lower_reg, 16'h0000}));
        if (acc_raw > iu_ext) begin
            integ_next = {integ_upper_reg, 16'h0000};
        end else if (acc_raw < il_ext) begin
            integ_next = {integ_lower_reg, 16'h0000};
        end else begin
            integ_next = acc_raw[INTEG_W-1:0];
        end
    end

    // output: exact Q.24 sum, clamp, else round half up to Q8.8
    always_comb begin
        sum     = SUM_W'($signed({prop_reg, 8'h00})) + SUM_W'(integ_reg);
        du_ext  = SUM_W'($signed({drive_upper_reg, 16'h0000}));
        dl_ext  = SUM_W'($signed({drive_lower_reg, 16'h0000}));
        sum_rnd = (sum + SUM_W'(32768)) >>> 16;
        if (sum > du_ext) begin
            drive_next   = drive_upper_reg;
            clamped_next = 1'b1;
        end else if (sum < dl_ext) begin
            drive_next   = drive_lower_reg;
            clamped_next = 1'b1;
        end else begin
            drive_next   = sum_rnd[DATA_W-1:0];
            clamped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            err_reg <= ERR_W'(s_target_value) - ERR_W'(s_sensed_value);
        end
        if (cmd.mul) begin
            prop_reg <= PROP_W'(prop_gain_reg) * PROP_W'(err_reg);
            gs_reg   <= GS_W'(integ_gain_reg) * $signed(GS_W'(step_time_reg));
            esum_reg <= ESUM_W'(err_reg) + ESUM_W'(last_err_reg);
        end
        if (cmd.prod) begin
            inc_reg <= INC_W'(gs_reg) * INC_W'(esum_reg);
        end
        if (cmd.drive) begin
            drive_reg   <= drive_next;
            clamped_reg <= clamped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg     <= '0;
            last_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accum) begin
                integ_reg    <= integ_next;
                last_err_reg <= err_reg;
            end
            if (cmd.drive) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free    = !out_valid_reg || m_ready;
    assign m_valid          = out_valid_reg;
    assign m_drive_value    = drive_reg;
    assign m_drive_clamped  = clamped_reg;

endmodule

FILE: design/pi_controller_clamped.sv
// Clamped PI controller top level: handshake ports, sequencer and datapath.
// Each item (setpoint and measurement, signed Q8.8) gives one result: the
// controller output in Q8.8 and a flag set when an output bound was applied.
// Steps from an item's acceptance to its result being loaded into the
// output register: error and two parallel products, the integrator increment
// product, the integrator update and clamp, then the output sum and clamp.
// These steps run in sequence on one set of registers, so a new item is
// accepted only when idle or in the cycle the previous result is loaded;
// a result waiting at m_ that is not taken holds the next one back. Registers
// are written through cfg_wr_en/cfg_index/cfg_data; the user must write them
// only while idle (not enforced by the block); indexes above 6 are ignored.
module pi_controller_clamped (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  pic_pkg::reg_idx_t                cfg_index,
    input  logic        [pic_pkg::DATA_W-1:0] cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [pic_pkg::DATA_W-1:0] s_target_value,
    input  logic signed [pic_pkg::DATA_W-1:0] s_sensed_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [pic_pkg::DATA_W-1:0] m_drive_value,
    output logic                             m_drive_clamped
);
    import pic_pkg::*;

    pic_cmd_t  cmd;
    pic_stat_t stat;

    pic_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pic_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_target_value  (s_target_value),
        .s_sensed_value  (s_sensed_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_value   (m_drive_value),
        .m_drive_clamped (m_drive_clamped),
        .cmd             (cmd),
        .stat            (stat)
    );

`ifndef SYNTHESIS
    // an accepted item keeps s_ready low through the mul, prod and accum steps
    a_item_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready ##1 !s_ready ##1 !s_ready)
        else $error("item accepted while previous item in flight");

    // a result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.drive && m_valid && !m_ready))
        else $error("result register overwritten");

    // the sequencer only issues one step per cycle
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.mul, cmd.prod, cmd.accum, cmd.drive}))
        else $error("multiple datapath steps in one cycle");
`endif

endmodule

FILE: dv/tb_pi_controller_clamped.sv
// Self-checking testbench for the clamped PI controller: directed, pressure and random tests.
module tb_pi_controller_clamped;
    timeunit 1ns;
    timeprecision 1ps;

    import pic_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 120;
    localparam int INC_SHIFT      = 9;   // Q.32 increment, halved, to Q8.24
    localparam int OUT_SHIFT      = 16;  // Q.24 sum to Q8.8
    localparam int BOUND_SHIFT    = 16;  // Q8.8 bound to Q.24

    localparam reg_idx_t REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] drive_value;
        logic              drive_clamped;
    } drive_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_wr_en;
    reg_idx_t                 cfg_index;
    logic        [DATA_W-1:0] cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_target_value;
    logic signed [DATA_W-1:0] s_sensed_value;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_drive_value;
    logic                     m_drive_clamped;

    pi_controller_clamped DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_target_value  (s_target_value),
        .s_sensed_value  (s_sensed_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_value   (m_drive_value),
        .m_drive_clamped (m_drive_clamped)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // controller shadow: register copies and loop state
    longint kp_q8     = 0;
    longint ki_q8     = 0;
    longint step_q16  = 0;
    longint integ_hi  = 32767;
    longint integ_lo  = -32768;
    longint drive_hi  = 32767;
    longint drive_lo  = -32768;
    longint integ_q24 = 0;
    longint prev_err  = 0;

    drive_result_t drive_expected_q[$];
    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int stall_cycles   = 0;

    function automatic void apply_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
        case (idx)
            REG_PROP_GAIN:   kp_q8    = longint'($signed(data));
            REG_INTEG_GAIN:  ki_q8    = longint'($signed(data));
            REG_STEP_TIME:   step_q16 = longint'(data);
            REG_INTEG_UPPER: integ_hi = longint'($signed(data));
            REG_INTEG_LOWER: integ_lo = longint'($signed(data));
            REG_DRIVE_UPPER: drive_hi = longint'($signed(data));
            REG_DRIVE_LOWER: drive_lo = longint'($signed(data));
            default: ;
        endcase
    endfunction

    // one control step: advances the integrator and returns the drive result
    function automatic drive_result_t pi_step(input logic signed [DATA_W-1:0] tgt,
                                              input logic signed [DATA_W-1:0] sns);
        longint err, prop, inc, acc, sum, drive;
        drive_result_t r;
        err  = longint'(tgt) - longint'(sns);
        prop = kp_q8 * err;
        inc  = ki_q8 * step_q16 * (err + prev_err);
        acc  = integ_q24 + ((inc + (longint'(1) <<< (INC_SHIFT - 1))) >>> INC_SHIFT);
        if (acc > (integ_hi <<< BOUND_SHIFT))
            acc = integ_hi <<< BOUND_SHIFT;
        else if (acc < (integ_lo <<< BOUND_SHIFT))
            acc = integ_lo <<< BOUND_SHIFT;
        integ_q24 = acc;
        sum = (prop <<< 8) + acc;
        r.drive_clamped = 1'b1;
        if (sum > (drive_hi <<< BOUND_SHIFT))
            drive = drive_hi;
        else if (sum < (drive_lo <<< BOUND_SHIFT))
            drive = drive_lo;
        else begin
            drive = (sum + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
            r.drive_clamped = 1'b0;
        end
        prev_err = err;
        r.drive_value = DATA_W'(drive);
        return r;
    endfunction

    task automatic set_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        apply_reg(idx, data);
    endtask

    // returns at the accepting edge with s_valid still high
    task automatic send_item(input logic signed [DATA_W-1:0] tgt,
                             input logic signed [DATA_W-1:0] sns);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_target_value <= tgt;
        s_sensed_value <= sns;
        do @(posedge aclk); while (!s_ready);
        drive_expected_q.push_back(pi_step(tgt, sns));
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (drive_expected_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] rand_gain();
        if ($urandom_range(3) == 0) return DATA_W'($urandom);
        return DATA_W'(int'($urandom_range(1024)) - 512);
    endfunction

    task automatic rand_bounds(output logic signed [DATA_W-1:0] hi,
                               output logic signed [DATA_W-1:0] lo);
        logic signed [DATA_W-1:0] t;
        if ($urandom_range(4) == 0) begin
            hi = BOUND_MAX;
            lo = BOUND_MIN;
        end else begin
            hi = DATA_W'($urandom);
            lo = DATA_W'($urandom);
            // mostly well ordered, sometimes left inverted
            if (hi < lo && $urandom_range(4) != 0) begin
                t  = hi;
                hi = lo;
                lo = t;
            end
        end
    endtask

    task automatic load_random_config();
        logic signed [DATA_W-1:0] hi, lo;
        set_reg(REG_PROP_GAIN, rand_gain());
        set_reg(REG_INTEG_GAIN, rand_gain());
        set_reg(REG_STEP_TIME, DATA_W'($urandom));
        rand_bounds(hi, lo);
        set_reg(REG_INTEG_UPPER, hi);
        set_reg(REG_INTEG_LOWER, lo);
        rand_bounds(hi, lo);
        set_reg(REG_DRIVE_UPPER, hi);
        set_reg(REG_DRIVE_LOWER, lo);
    endtask

    task automatic send_random_item();
        logic signed [DATA_W-1:0] tgt, sns;
        tgt = DATA_W'($urandom);
        // small errors keep the loop near its bounds; the rest spans the full range
        if ($urandom_range(9) < 7)
            sns = tgt + DATA_W'(int'($urandom_range(600)) - 300);
        else
            sns = DATA_W'($urandom);
        send_item(tgt, sns);
    endtask

    task automatic test_reset_defaults();
        send_item(16'sh7fff, 16'sh8000);
        send_item(16'sh8000, 16'sh7fff);
        send_item(16'sh0000, 16'sh0000);
        wait_for_results();
    endtask

    task automatic test_proportional();
        set_reg(REG_PROP_GAIN, 16'h0100);
        send_item(16'sd100, -16'sd100);
        send_item(16'sh7fff, 16'sh8000);   // upper output clamp
        send_item(16'sh8000, 16'sh7fff);   // lower output clamp
        wait_for_results();
        set_reg(REG_PROP_GAIN, 16'h0080);
        send_item(16'sd1, 16'sd0);         // exact half rounds up
        send_item(16'sd0, 16'sd1);
        wait_for_results();
        set_reg(REG_PROP_GAIN, BOUND_MIN);
        send_item(16'sd1, 16'sd0);
        wait_for_results();
        set_reg(REG_PROP_GAIN, BOUND_MAX);
        send_item(16'sh7fff, 16'sh8000);
        wait_for_results();
    endtask

    task automatic test_integrator();
        set_reg(REG_PROP_GAIN, 16'h0000);
        set_reg(REG_INTEG_GAIN, BOUND_MAX);
        set_reg(REG_STEP_TIME, 16'hffff);
        set_reg(REG_INTEG_UPPER, 16'h0100);
        set_reg(REG_INTEG_LOWER, 16'hff00);
        // integrator saturates both ways; the output flag stays clear
        send_item(16'sh7fff, 16'sh8000);
        send_item(16'sh7fff, 16'sh8000);
        send_item(16'sh8000, 16'sh7fff);
        send_item(16'sh8000, 16'sh7fff);
        wait_for_results();
        set_reg(REG_INTEG_GAIN, 16'h0001);
        set_reg(REG_STEP_TIME, 16'h0001);
        send_item(16'sd128, 16'sd0);
        send_item(16'sd128, 16'sd0);
        wait_for_results();
    endtask

    task automatic test_inverted_bounds();
        set_reg(REG_PROP_GAIN, 16'h0100);
        set_reg(REG_INTEG_GAIN, 16'h0100);
        set_reg(REG_STEP_TIME, 16'h8000);
        set_reg(REG_INTEG_UPPER, 16'hff00);
        set_reg(REG_INTEG_LOWER, 16'h0100);
        set_reg(REG_DRIVE_UPPER, BOUND_MIN);
        set_reg(REG_DRIVE_LOWER, BOUND_MAX);
        send_item(16'sd0, 16'sd0);
        send_item(16'sh7fff, 16'sh8000);
        wait_for_results();
        set_reg(REG_DRIVE_UPPER, 16'hfe00);
        set_reg(REG_DRIVE_LOWER, 16'h0200);
        send_item(16'sh8000, 16'sh7fff);
        send_item(16'sd300, 16'sd0);
        wait_for_results();
        set_reg(REG_INTEG_UPPER, BOUND_MAX);
        set_reg(REG_INTEG_LOWER, BOUND_MIN);
        set_reg(REG_DRIVE_UPPER, BOUND_MAX);
        set_reg(REG_DRIVE_LOWER, BOUND_MIN);
    endtask

    task automatic test_unused_index();
        set_reg(REG_UNUSED, 16'hffff);
        send_item(16'sd512, 16'sd256);
        send_item(-16'sd512, 16'sd256);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = HOLD_CYCLES;
        repeat (12) send_random_item();
        wait_for_results();
    endtask

    task automatic test_random();
        int send_pct[4] = '{0, 77, 0, 7};
        int recv_pct[4] = '{0, 0, 77, 7};
        for (int ph = 0; ph < 4; ph++) begin
            load_random_config();
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            repeat (PHASE_ITEMS) send_random_item();
            wait_for_results();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_len != 0) begin
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        drive_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (drive_expected_q.size() == 0) begin
                $error("unexpected item: drive_value %0d drive_clamped %0b",
                       m_drive_value, m_drive_clamped);
                mismatch_count++;
            end else begin
                want = drive_expected_q.pop_front();
                if (m_drive_value !== want.drive_value) begin
                    $error("drive_value: expected %0d, got %0d",
                           $signed(want.drive_value), m_drive_value);
                    mismatch_count++;
                end
                if (m_drive_clamped !== want.drive_clamped) begin
                    $error("drive_clamped: expected %0b, got %0b",
                           want.drive_clamped, m_drive_clamped);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_PROP_GAIN;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_target_value = '0;
        s_sensed_value = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_proportional();
        test_integrator();
        test_inverted_bounds();
        test_unused_index();
        test_backpressure();
        test_random();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
